@@ rtl/core/tmpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tmpf_pkg
// shared types and constants of the trimmed-mean pH filter
// ----------------------------------------------------------------------------
package tmpf_pkg;

	localparam int SAMPLE_W = 12;
	localparam int PH_W     = 12;
	localparam int TSUM_W   = 15;
	localparam int OFFS_W   = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	// pH scale: sum * 3.3 * 3.5 * 256 / (4096 * 6) ~ (sum * 31539) >> 18
	localparam int SCALE_W     = 15;
	localparam logic [SCALE_W-1:0] PH_SCALE_MUL = 15'd31539;
	localparam int PH_SCALE_SHIFT = 18;

	localparam logic [PH_W-1:0]   PH_MAX  = 12'd4095;
	localparam logic [TSUM_W-1:0] TSUM_MAX = 15'd32767;

	localparam logic [CFG_IDX_W-1:0] REG_PH_OFFSET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PH_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PH_LOW_LIMIT  = 2'd2;

	localparam logic [OFFS_W-1:0] PH_OFFSET_RST     = 12'd0;
	localparam logic [PH_W-1:0]   PH_HIGH_LIMIT_RST = 12'd2048;
	localparam logic [PH_W-1:0]   PH_LOW_LIMIT_RST  = 12'd1664;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_PLACE = 6'b000100,
		S_SUM   = 6'b001000,
		S_MUL   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

endpackage

@@ rtl/core/trimmed_mean_ph_filter.sv @@
// ----------------------------------------------------------------------------
// trimmed_mean_ph_filter
// Collects 12-bit pH probe samples in groups of GROUP_SIZE and, once a group
// is complete, emits one beat: the sum of the middle samples (TRIM_EACH_END
// dropped at each end), that sum scaled to pH in 1/256 units plus the signed
// offset and saturated to 0..4095, and an alarm flag against the limits.
// Samples are kept sorted in a single-port-read buffer: each sample is
// insertion-sorted on arrival. The first sample of a group is written
// directly; any other is placed after a scan over the stored samples above
// it. A new sample is accepted only once the previous one is placed. The
// last sample of a group is followed by a pass over the kept entries (when
// any are kept), a multiply step and a result step, plus any wait for the
// previous result beat to leave. Registers are sampled when the result is
// formed; a new sample is taken while a result beat still waits.
// ----------------------------------------------------------------------------
module trimmed_mean_ph_filter #(
	parameter int GROUP_SIZE    = 10,
	parameter int TRIM_EACH_END = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tmpf_pkg::SAMPLE_W-1:0]       adc_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tmpf_pkg::PH_W-1:0]           ph_value,
	output logic                                ph_alarm,
	output logic [tmpf_pkg::TSUM_W-1:0]         trimmed_sum,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tmpf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tmpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int ADDR_W = $clog2(GROUP_SIZE);
	localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
	localparam int KEEP   = (GROUP_SIZE > 2 * TRIM_EACH_END) ?
		GROUP_SIZE - 2 * TRIM_EACH_END : 0;
	localparam int START  = (KEEP > 0) ? TRIM_EACH_END : 0;
	localparam int STOP   = START + KEEP;
	localparam int SUM_W  = $clog2(GROUP_SIZE * (1 << tmpf_pkg::SAMPLE_W));
	localparam int PROD_W = SUM_W + tmpf_pkg::SCALE_W;
	localparam int PHS_W  = PROD_W - tmpf_pkg::PH_SCALE_SHIFT;
	localparam int SADD_W = PHS_W + 2;

	tmpf_pkg::state_t state_q;

	logic [tmpf_pkg::SAMPLE_W-1:0] mem [GROUP_SIZE];
	logic [tmpf_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]             rd_addr;
	logic                          wr_en;
	logic [ADDR_W-1:0]             wr_addr;
	logic [tmpf_pkg::SAMPLE_W-1:0] wr_data;

	logic [ADDR_W-1:0]             count_q;
	logic [ADDR_W-1:0]             pos_q;
	logic [tmpf_pkg::SAMPLE_W-1:0] key_q;
	logic [CNT_W-1:0]              r_q;
	logic                          pend_q;
	logic [SUM_W-1:0]              acc_q;
	logic [PROD_W-1:0]             prod_q;

	logic [tmpf_pkg::OFFS_W-1:0]   offset_q;
	logic [tmpf_pkg::PH_W-1:0]     high_q;
	logic [tmpf_pkg::PH_W-1:0]     low_q;

	logic                          out_valid_q;
	logic [tmpf_pkg::PH_W-1:0]     ph_value_q;
	logic                          ph_alarm_q;
	logic [tmpf_pkg::TSUM_W-1:0]   tsum_q;

	logic                          in_beat;
	logic                          gt;
	logic                          ins_done;
	logic                          group_full;
	logic                          out_free;
	logic [PHS_W-1:0]              ph_shift;
	logic signed [SADD_W-1:0]      ph_sum;
	logic [tmpf_pkg::PH_W-1:0]     ph_sat;
	logic [tmpf_pkg::TSUM_W-1:0]   tsum_sat;

	assign in_ready   = (state_q == tmpf_pkg::S_IDLE);
	assign in_beat    = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || out_ready;
	assign gt         = rd_data_q > key_q;
	assign group_full = (CNT_W'(count_q) + CNT_W'(1)) == CNT_W'(GROUP_SIZE);

	// buffer port control
	always_comb begin
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = key_q;
		ins_done = 1'b0;
		unique case (state_q)
			tmpf_pkg::S_IDLE: begin
				if (in_beat) begin
					if (count_q == '0) begin
						wr_en    = 1'b1;
						wr_data  = adc_sample;
						ins_done = 1'b1;
					end else begin
						rd_addr = count_q - ADDR_W'(1);
					end
				end
			end
			tmpf_pkg::S_SCAN: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				if (gt) begin
					wr_data = rd_data_q;
					rd_addr = pos_q - ADDR_W'(2);
				end else begin
					ins_done = 1'b1;
				end
			end
			tmpf_pkg::S_PLACE: begin
				wr_en    = 1'b1;
				ins_done = 1'b1;
			end
			tmpf_pkg::S_SUM: begin
				rd_addr = r_q[ADDR_W-1:0];
			end
			tmpf_pkg::S_MUL, tmpf_pkg::S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// sorted sample buffer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// scaling, offset and saturation
	assign ph_shift = prod_q[PROD_W-1:tmpf_pkg::PH_SCALE_SHIFT];
	assign ph_sum   = signed'({2'b00, ph_shift}) +
		SADD_W'(signed'(offset_q));

	always_comb begin
		priority if (ph_sum < 0) begin
			ph_sat = '0;
		end else if (ph_sum > SADD_W'(tmpf_pkg::PH_MAX)) begin
			ph_sat = tmpf_pkg::PH_MAX;
		end else begin
			ph_sat = ph_sum[tmpf_pkg::PH_W-1:0];
		end
	end

	assign tsum_sat = (acc_q > SUM_W'(tmpf_pkg::TSUM_MAX)) ?
		tmpf_pkg::TSUM_MAX : acc_q[tmpf_pkg::TSUM_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmpf_pkg::S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tmpf_pkg::S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tmpf_pkg::S_IDLE: begin
					if (in_beat && count_q != '0) begin
						state_q <= tmpf_pkg::S_SCAN;
					end
				end
				tmpf_pkg::S_SCAN: begin
					if (gt && pos_q == ADDR_W'(1)) begin
						state_q <= tmpf_pkg::S_PLACE;
					end
				end
				tmpf_pkg::S_PLACE: begin
				end
				tmpf_pkg::S_SUM: begin
					pend_q <= (r_q < CNT_W'(STOP));
					if (r_q == CNT_W'(STOP) && !pend_q) begin
						state_q <= tmpf_pkg::S_MUL;
					end
				end
				tmpf_pkg::S_MUL: begin
					state_q <= tmpf_pkg::S_FIN;
				end
				tmpf_pkg::S_FIN: begin
					if (out_free) begin
						state_q <= tmpf_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= tmpf_pkg::S_IDLE;
				end
			endcase
			if (ins_done) begin
				if (group_full) begin
					count_q <= '0;
					pend_q  <= 1'b0;
					state_q <= tmpf_pkg::S_SUM;
				end else begin
					count_q <= count_q + ADDR_W'(1);
					state_q <= tmpf_pkg::S_IDLE;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			key_q <= adc_sample;
			pos_q <= count_q;
		end
		if (state_q == tmpf_pkg::S_SCAN && gt) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
		if (ins_done && group_full) begin
			r_q   <= CNT_W'(START);
			acc_q <= '0;
		end
		if (state_q == tmpf_pkg::S_SUM) begin
			if (r_q < CNT_W'(STOP)) begin
				r_q <= r_q + CNT_W'(1);
			end
			if (pend_q) begin
				acc_q <= acc_q + SUM_W'(rd_data_q);
			end
		end
		if (state_q == tmpf_pkg::S_MUL) begin
			prod_q <= PROD_W'(acc_q) * PROD_W'(tmpf_pkg::PH_SCALE_MUL);
		end
		if (state_q == tmpf_pkg::S_FIN && out_free) begin
			ph_value_q <= ph_sat;
			ph_alarm_q <= (ph_sat > high_q) || (ph_sat < low_q);
			tsum_q     <= tsum_sat;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= tmpf_pkg::PH_OFFSET_RST;
			high_q   <= tmpf_pkg::PH_HIGH_LIMIT_RST;
			low_q    <= tmpf_pkg::PH_LOW_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tmpf_pkg::REG_PH_OFFSET:     offset_q <= cfg_data;
				tmpf_pkg::REG_PH_HIGH_LIMIT: high_q   <= cfg_data;
				tmpf_pkg::REG_PH_LOW_LIMIT:  low_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign ph_value    = ph_value_q;
	assign ph_alarm    = ph_alarm_q;
	assign trimmed_sum = tsum_q;

endmodule

@@ bench/ph_filter_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_filter_checker
// Watches the sample, result and register channels of the trimmed-mean pH
// filter. Every tenth accepted sample closes a group: the group is sorted,
// the middle values summed, scaled to pH, offset, saturated and compared
// against the alarm limits in effect. The resulting reading is queued and
// each result beat is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module ph_filter_checker #(
	parameter int GROUP_SIZE    = 10,
	parameter int TRIM_EACH_END = 2
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	input  logic                                      in_ready,
	input  logic [tmpf_pkg::SAMPLE_W-1:0]             adc_sample,
	input  logic                                      out_valid,
	input  logic                                      out_ready,
	input  logic [tmpf_pkg::PH_W-1:0]                 ph_value,
	input  logic                                      ph_alarm,
	input  logic [tmpf_pkg::TSUM_W-1:0]               trimmed_sum,
	input  logic                                      cfg_valid,
	input  logic                                      cfg_ready,
	input  logic [tmpf_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [tmpf_pkg::CFG_DATA_W-1:0]           cfg_data,
	output int                                        failures,
	output int                                        outstanding
);

	typedef struct packed {
		logic [tmpf_pkg::PH_W-1:0]   ph_value;
		logic                        ph_alarm;
		logic [tmpf_pkg::TSUM_W-1:0] trimmed_sum;
	} ph_reading_t;

	logic [tmpf_pkg::SAMPLE_W-1:0]      group_buf [GROUP_SIZE];
	int                                 group_fill;
	logic signed [tmpf_pkg::OFFS_W-1:0] offset_q;
	logic [tmpf_pkg::PH_W-1:0]          high_q;
	logic [tmpf_pkg::PH_W-1:0]          low_q;
	ph_reading_t                        readings_due [$];
	ph_reading_t                        want;

	function automatic ph_reading_t filter_group();
		logic [tmpf_pkg::SAMPLE_W-1:0] sorted [GROUP_SIZE];
		logic [tmpf_pkg::SAMPLE_W-1:0] key;
		logic [31:0]                   kept_sum;
		logic [47:0]                   scaled;
		int                            j;
		int                            ph;
		ph_reading_t                   r;
		sorted = group_buf;
		for (int i = 1; i < GROUP_SIZE; i++) begin
			key = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > key) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = key;
		end
		kept_sum = '0;
		for (int i = TRIM_EACH_END; i < GROUP_SIZE - TRIM_EACH_END; i++)
			kept_sum += 32'(sorted[i]);
		// scale factor stays at its six-sample value
		scaled = (48'(kept_sum) * 48'(tmpf_pkg::PH_SCALE_MUL)) >> tmpf_pkg::PH_SCALE_SHIFT;
		ph = int'(scaled) + int'(offset_q);
		if (ph < 0)
			ph = 0;
		if (ph > int'(tmpf_pkg::PH_MAX))
			ph = int'(tmpf_pkg::PH_MAX);
		r.ph_value    = ph[tmpf_pkg::PH_W-1:0];
		// alarm looks at the saturated value
		r.ph_alarm    = (r.ph_value > high_q) || (r.ph_value < low_q);
		r.trimmed_sum = (kept_sum > 32'(tmpf_pkg::TSUM_MAX)) ? tmpf_pkg::TSUM_MAX :
			kept_sum[tmpf_pkg::TSUM_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readings_due.delete();
			group_fill = 0;
			offset_q   = tmpf_pkg::PH_OFFSET_RST;
			high_q     = tmpf_pkg::PH_HIGH_LIMIT_RST;
			low_q      = tmpf_pkg::PH_LOW_LIMIT_RST;
			failures   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					$error("unexpected result beat: ph_value %0d ph_alarm %0d trimmed_sum %0d",
						ph_value, ph_alarm, trimmed_sum);
					failures++;
				end else begin
					want = readings_due.pop_front();
					if (ph_value !== want.ph_value) begin
						$error("ph_value: expected %0d, actual %0d", want.ph_value, ph_value);
						failures++;
					end
					if (ph_alarm !== want.ph_alarm) begin
						$error("ph_alarm: expected %0d, actual %0d", want.ph_alarm, ph_alarm);
						failures++;
					end
					if (trimmed_sum !== want.trimmed_sum) begin
						$error("trimmed_sum: expected %0d, actual %0d",
							want.trimmed_sum, trimmed_sum);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tmpf_pkg::REG_PH_OFFSET:     offset_q = cfg_data;
					tmpf_pkg::REG_PH_HIGH_LIMIT: high_q   = cfg_data;
					tmpf_pkg::REG_PH_LOW_LIMIT:  low_q    = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				group_buf[group_fill] = adc_sample;
				group_fill++;
				if (group_fill == GROUP_SIZE) begin
					readings_due.push_back(filter_group());
					group_fill = 0;
				end
			end
		end
		outstanding = readings_due.size();
	end

endmodule

@@ bench/trimmed_mean_ph_filter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_ph_filter_tb
// Feeds probe samples to the trimmed-mean pH filter: a few hand-built groups
// covering reset limits, extreme samples, saturation at zero, crossed
// limits, mid-group register writes and an unmapped register, then random
// groups of clustered readings with outliers under a series of register
// settings and sender/receiver throttling mixes. Checking is in the checker.
// ----------------------------------------------------------------------------
module trimmed_mean_ph_filter_tb;

	localparam int GROUP_SIZE    = 10;
	localparam int TRIM_EACH_END = 2;
	localparam int PHASES        = 8;
	localparam int PHASE_SAMPLES = 144;
	localparam int SETTLE_CYCLES = 48;
	localparam int LIMIT_CYCLES  = 500000;

	localparam logic [tmpf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [tmpf_pkg::SAMPLE_W-1:0]   adc_sample = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [tmpf_pkg::PH_W-1:0]       ph_value;
	logic                            ph_alarm;
	logic [tmpf_pkg::TSUM_W-1:0]     trimmed_sum;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [tmpf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tmpf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int failures;
	int outstanding;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	trimmed_mean_ph_filter #(
		.GROUP_SIZE   (GROUP_SIZE),
		.TRIM_EACH_END(TRIM_EACH_END)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ph_value   (ph_value),
		.ph_alarm   (ph_alarm),
		.trimmed_sum(trimmed_sum),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	ph_filter_checker #(
		.GROUP_SIZE   (GROUP_SIZE),
		.TRIM_EACH_END(TRIM_EACH_END)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.adc_sample (adc_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ph_value   (ph_value),
		.ph_alarm   (ph_alarm),
		.trimmed_sum(trimmed_sum),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.failures   (failures),
		.outstanding(outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("trimmed_mean_ph_filter_tb NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays up across back-to-back beats, drops only during a gap
	task automatic send_sample(input logic [tmpf_pkg::SAMPLE_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= value;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [tmpf_pkg::CFG_IDX_W-1:0] index,
		input logic [tmpf_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// clustered reading around a base, with stray and rail-to-rail outliers
	function automatic logic [tmpf_pkg::SAMPLE_W-1:0] probe_sample(input int base);
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 70) begin
			v = base + int'($urandom_range(400)) - 200;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
		end else if (pick < 88) begin
			v = $urandom_range(4095);
		end else begin
			v = $urandom_range(1) ? 4095 : 0;
		end
		return v[tmpf_pkg::SAMPLE_W-1:0];
	endfunction

	initial begin
		logic [tmpf_pkg::SAMPLE_W-1:0]   first_group [10];
		logic [tmpf_pkg::CFG_DATA_W-1:0] offs;
		logic [tmpf_pkg::CFG_DATA_W-1:0] hi;
		logic [tmpf_pkg::CFG_DATA_W-1:0] lo;
		int                              base;
		int                              sent;
		int                              idle_table [4];
		int                              stall_table [4];

		first_group = '{12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4095,
			12'd0, 12'd2048, 12'd1, 12'd4094, 12'd2047};
		idle_table  = '{0, 76, 0, 31};
		stall_table = '{0, 0, 76, 31};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset register values, outliers at both rails
		foreach (first_group[i])
			send_sample(first_group[i]);
		drain();

		// half a group, then crossed limits and a big negative offset
		repeat (5) send_sample(12'd3);
		drain();
		write_reg(tmpf_pkg::REG_PH_OFFSET, 12'h800);
		write_reg(tmpf_pkg::REG_PH_HIGH_LIMIT, 12'd0);
		write_reg(tmpf_pkg::REG_PH_LOW_LIMIT, 12'd4095);
		write_reg(REG_UNMAPPED, 12'hFFF);
		repeat (5) send_sample(12'd4095);
		drain();

		sent = 0;
		base = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					offs = 12'h7FF;
					hi   = tmpf_pkg::PH_MAX;
					lo   = 12'd0;
				end
				1: begin
					offs = 12'h800;
					hi   = 12'd0;
					lo   = 12'd0;
				end
				2: begin
					offs = tmpf_pkg::PH_OFFSET_RST;
					hi   = tmpf_pkg::PH_HIGH_LIMIT_RST;
					lo   = tmpf_pkg::PH_LOW_LIMIT_RST;
				end
				3: begin
					offs = 12'd0;
					hi   = 12'd1500;
					lo   = 12'd2500;
				end
				default: begin
					offs = tmpf_pkg::CFG_DATA_W'($urandom_range(4095));
					hi   = tmpf_pkg::CFG_DATA_W'($urandom_range(3200, 1200));
					lo   = tmpf_pkg::CFG_DATA_W'($urandom_range(2400, 800));
				end
			endcase
			write_reg(tmpf_pkg::REG_PH_OFFSET, offs);
			write_reg(tmpf_pkg::REG_PH_HIGH_LIMIT, hi);
			write_reg(tmpf_pkg::REG_PH_LOW_LIMIT, lo);
			if (ph % 3 == 0)
				write_reg(REG_UNMAPPED, tmpf_pkg::CFG_DATA_W'($urandom_range(4095)));
			sender_idle_pct = idle_table[ph % 4];
			recv_stall_pct  = stall_table[ph % 4];
			for (int k = 0; k < PHASE_SAMPLES; k++) begin
				if (sent % GROUP_SIZE == 0)
					base = $urandom_range(4095);
				send_sample(probe_sample(base));
				sent++;
			end
			drain();
			sender_idle_pct = 0;
			recv_stall_pct  = 0;
		end

		if (failures == 0 && outstanding == 0)
			$display("trimmed_mean_ph_filter_tb OK");
		else
			$display("trimmed_mean_ph_filter_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/tmpf_pkg.sv
rtl/core/trimmed_mean_ph_filter.sv
bench/ph_filter_checker.sv
bench/trimmed_mean_ph_filter_tb.sv
